[sv/lsb_stego_frame_extractor_top_assert.svh]
// Assertion macros for the frame extractor, clocked on clk, off during reset.
`ifndef LSB_STEGO_FRAME_EXTRACTOR_TOP_ASSERT_SVH
`define LSB_STEGO_FRAME_EXTRACTOR_TOP_ASSERT_SVH

// same-cycle implication
`define LSBSE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define LSBSE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[sv/lsbse_pkg.sv]
package lsbse_pkg;

	localparam logic [1:0] PH_CRC  = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_PAY  = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [1:0] ST_PROGRESS = 2'd0;
	localparam logic [1:0] ST_MATCH    = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_CAPACITY = 2'd3;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	typedef struct packed {
		logic       frame_start;
		logic [7:0] cover_byte;
	} in_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] payload_byte;
		logic       last_result;
		logic [1:0] status;
	} out_t;

endpackage

[sv/lsb_stego_frame_extractor_top.sv]
// LSB steganography extractor with CRC-32 check.
// Input channel: in_valid / in_stall / in_data, one pixel component byte per
// item; in_data.frame_start marks the first byte of an image. Bit 0 of each
// byte is collected LSB first: 4 bytes stored CRC, 4 bytes length, then payload.
// Output channel: out_valid / out_stall / out_data. One item per payload byte;
// the last item of a frame carries the match, mismatch or capacity status.
// Header bytes give no item, except a capacity error or empty payload.
// cfg_we / cfg_wdata write cover_byte_count; write it only while idle.
// Throughput: one input item per cycle while in_stall is low. An accepted item
// passes the input register, then the result register, before out_data.
// A stalled output holds its item; the input register keeps accepting while it
// is empty or the result register is free or being taken, else in_stall rises.
// Reset: cover_byte_count 0, extraction state cleared, both registers empty.
`include "lsb_stego_frame_extractor_top_assert.svh"

module lsb_stego_frame_extractor_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lsbse_pkg::in_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output lsbse_pkg::out_t  out_data,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata
);

	logic            s1_valid_s1;
	lsbse_pkg::in_t  s1_data_s1;
	logic            out_valid_q;
	lsbse_pkg::out_t out_q;
	logic [31:0]     cover_count_q;

	logic [2:0]  bit_pos_q;
	logic [7:0]  gather_q;
	logic [1:0]  phase_q;
	logic [1:0]  hdr_idx_q;
	logic [31:0] stored_crc_q;
	logic [31:0] rem_len_q;
	logic [31:0] run_crc_q;

	logic        in_acc;
	logic        s1_adv;
	logic        out_load;

	logic [2:0]  e_bit_pos;
	logic [7:0]  e_gather;
	logic [1:0]  e_phase;
	logic [1:0]  e_hdr_idx;
	logic [31:0] e_stored_crc;
	logic [31:0] e_rem_len;
	logic [31:0] e_run_crc;

	logic [7:0]  done_byte;
	logic [31:0] hdr_word;
	logic [31:0] crc_upd;

	logic [2:0]  n_bit_pos;
	logic [7:0]  n_gather;
	logic [1:0]  n_phase;
	logic [1:0]  n_hdr_idx;
	logic [31:0] n_stored_crc;
	logic [31:0] n_rem_len;
	logic [31:0] n_run_crc;
	logic        res_valid;
	lsbse_pkg::out_t res;

	assign s1_adv   = s1_valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_s1 && !s1_adv;
	assign in_acc   = in_valid && !in_stall;
	assign out_load = s1_adv && res_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (s1_data_s1.frame_start) begin
			e_bit_pos    = 3'd0;
			e_gather     = 8'd0;
			e_phase      = lsbse_pkg::PH_CRC;
			e_hdr_idx    = 2'd0;
			e_stored_crc = 32'd0;
			e_rem_len    = 32'd0;
			e_run_crc    = lsbse_pkg::CRC_INIT;
		end else begin
			e_bit_pos    = bit_pos_q;
			e_gather     = gather_q;
			e_phase      = phase_q;
			e_hdr_idx    = hdr_idx_q;
			e_stored_crc = stored_crc_q;
			e_rem_len    = rem_len_q;
			e_run_crc    = run_crc_q;
		end
	end

	assign done_byte = e_gather | (8'(s1_data_s1.cover_byte[0]) << e_bit_pos);
	assign hdr_word  = {24'd0, done_byte} << {e_hdr_idx, 3'b000};

	lsbse_crc_byte u_crc (
		.crc      (e_run_crc),
		.data     (done_byte),
		.crc_next (crc_upd)
	);

	always_comb begin
		n_bit_pos    = e_bit_pos;
		n_gather     = e_gather;
		n_phase      = e_phase;
		n_hdr_idx    = e_hdr_idx;
		n_stored_crc = e_stored_crc;
		n_rem_len    = e_rem_len;
		n_run_crc    = e_run_crc;
		res_valid    = 1'b0;
		res          = '0;
		if (e_phase != lsbse_pkg::PH_DONE) begin
			if (e_bit_pos != 3'd7) begin
				n_bit_pos = e_bit_pos + 3'd1;
				n_gather  = done_byte;
			end else begin
				n_bit_pos = 3'd0;
				n_gather  = 8'd0;
				case (e_phase)
					lsbse_pkg::PH_CRC: begin
						n_stored_crc = e_stored_crc | hdr_word;
						n_hdr_idx    = e_hdr_idx + 2'd1;
						if (e_hdr_idx == 2'd3) begin
							n_phase = lsbse_pkg::PH_LEN;
						end
					end
					lsbse_pkg::PH_LEN: begin
						n_rem_len = e_rem_len | hdr_word;
						n_hdr_idx = e_hdr_idx + 2'd1;
						if (e_hdr_idx == 2'd3) begin
							if ({4'd0, cover_count_q[31:3]} < ({1'b0, n_rem_len} + 33'd8)) begin
								n_phase         = lsbse_pkg::PH_DONE;
								res_valid       = 1'b1;
								res.last_result = 1'b1;
								res.status      = lsbse_pkg::ST_CAPACITY;
							end else if (n_rem_len == 32'd0) begin
								n_phase         = lsbse_pkg::PH_DONE;
								res_valid       = 1'b1;
								res.last_result = 1'b1;
								res.status      = (e_stored_crc == 32'd0) ?
									lsbse_pkg::ST_MATCH : lsbse_pkg::ST_MISMATCH;
							end else begin
								n_phase = lsbse_pkg::PH_PAY;
							end
						end
					end
					lsbse_pkg::PH_PAY: begin
						n_run_crc        = crc_upd;
						n_rem_len        = e_rem_len - 32'd1;
						res_valid        = 1'b1;
						res.has_byte     = 1'b1;
						res.payload_byte = done_byte;
						if (e_rem_len == 32'd1) begin
							n_phase         = lsbse_pkg::PH_DONE;
							res.last_result = 1'b1;
							res.status      = ((~crc_upd) == e_stored_crc) ?
								lsbse_pkg::ST_MATCH : lsbse_pkg::ST_MISMATCH;
						end
					end
					default: begin
						n_phase = e_phase;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
			cover_count_q <= 32'd0;
			bit_pos_q     <= 3'd0;
			gather_q      <= 8'd0;
			phase_q       <= lsbse_pkg::PH_CRC;
			hdr_idx_q     <= 2'd0;
			stored_crc_q  <= 32'd0;
			rem_len_q     <= 32'd0;
			run_crc_q     <= lsbse_pkg::CRC_INIT;
		end else begin
			s1_valid_s1 <= in_acc || (s1_valid_s1 && !s1_adv);
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				cover_count_q <= cfg_wdata;
			end
			if (s1_adv) begin
				bit_pos_q    <= n_bit_pos;
				gather_q     <= n_gather;
				phase_q      <= n_phase;
				hdr_idx_q    <= n_hdr_idx;
				stored_crc_q <= n_stored_crc;
				rem_len_q    <= n_rem_len;
				run_crc_q    <= n_run_crc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_data_s1 <= in_data;
		end
		if (out_load) begin
			out_q <= res;
		end
	end

	`LSBSE_ASSERT_IMP(a_last_has_status, out_valid_q && out_q.last_result, out_q.status != lsbse_pkg::ST_PROGRESS)
	`LSBSE_ASSERT_IMP(a_mid_is_byte, out_valid_q && !out_q.last_result, out_q.has_byte && out_q.status == lsbse_pkg::ST_PROGRESS)
	`LSBSE_ASSERT_IMP(a_done_aligned, phase_q == lsbse_pkg::PH_DONE, bit_pos_q == 3'd0 && gather_q == 8'd0)
	`LSBSE_ASSERT_NXT(a_last_ends_frame, out_load && res.last_result, phase_q == lsbse_pkg::PH_DONE)

endmodule

[sv/lsbse_crc_byte.sv]
module lsbse_crc_byte (
	input  logic [31:0] crc,
	input  logic [7:0]  data,
	output logic [31:0] crc_next
);

	// reflected CRC-32, one byte; unrolls to an XOR network
	always_comb begin
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ lsbse_pkg::CRC_POLY) : (c >> 1);
		end
		crc_next = c;
	end

endmodule

[test/lsb_stego_frame_extractor_top_tb.sv]
`timescale 1ns / 100ps

module lsb_stego_frame_extractor_top_tb;

	typedef struct {
		logic [31:0] cfg;
		logic [31:0] crc;
		logic [31:0] len;
		bit          fix_crc;
		int          fill;
		bit          start;
		int          nbits;
		int          tail;
		bit          typed;
		logic [1:0]  st;
	} frame_row_t;

	localparam int NROWS = 15;
	localparam logic [31:0] CFG_MAX = 32'hFFFFFFFF;

	// cfg, crc, len, fix_crc, fill, start, nbits, tail, typed, status
	frame_row_t dir_rows [NROWS] = '{
		'{32'd0, 32'h0, 32'h0, 1'b0, -1, 1'b0, 0, 3, 1'b1, lsbse_pkg::ST_CAPACITY},
		'{32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, -1, 1'b1, 0, 2, 1'b1, lsbse_pkg::ST_CAPACITY},
		'{CFG_MAX, 32'h0, 32'h0, 1'b0, -1, 1'b1, 0, 2, 1'b1, lsbse_pkg::ST_MATCH},
		'{CFG_MAX, 32'hDEADBEEF, 32'h0, 1'b0, -1, 1'b1, 0, 0, 1'b1, lsbse_pkg::ST_MISMATCH},
		'{CFG_MAX, 32'h12345678, 32'hFFFFFFFF, 1'b0, -1, 1'b1, 0, 0, 1'b1,
			lsbse_pkg::ST_CAPACITY},
		'{CFG_MAX, 32'h0, 32'hFFFFFFF8, 1'b0, -1, 1'b1, 0, 0, 1'b1, lsbse_pkg::ST_CAPACITY},
		'{CFG_MAX, 32'h0, 32'h1FFFFFF7, 1'b0, -1, 1'b1, 91, 0, 1'b0, lsbse_pkg::ST_PROGRESS},
		'{CFG_MAX, 32'h0, 32'd4, 1'b1, -1, 1'b1, 0, 5, 1'b0, lsbse_pkg::ST_PROGRESS},
		'{CFG_MAX, 32'hA5A5A5A5, 32'd3, 1'b0, -1, 1'b1, 0, 0, 1'b0, lsbse_pkg::ST_PROGRESS},
		'{32'd104, 32'h0, 32'd5, 1'b1, -1, 1'b1, 0, 0, 1'b0, lsbse_pkg::ST_PROGRESS},
		'{32'd103, 32'h0, 32'd5, 1'b1, -1, 1'b1, 0, 0, 1'b1, lsbse_pkg::ST_CAPACITY},
		'{32'd103, 32'h0, 32'd4, 1'b1, 255, 1'b1, 0, 0, 1'b0, lsbse_pkg::ST_PROGRESS},
		'{32'd103, 32'h0, 32'd2, 1'b1, 0, 1'b1, 37, 0, 1'b0, lsbse_pkg::ST_PROGRESS},
		'{32'd103, 32'h0, 32'd3, 1'b1, 0, 1'b1, 0, 2, 1'b0, lsbse_pkg::ST_PROGRESS},
		'{CFG_MAX, 32'h0, 32'd2, 1'b0, -1, 1'b1, 0, 0, 1'b0, lsbse_pkg::ST_PROGRESS}
	};

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	lsbse_pkg::in_t  in_data;
	logic            out_valid;
	logic            out_stall;
	lsbse_pkg::out_t out_data;
	logic            cfg_we;
	logic [31:0]     cfg_wdata;

	// predictor state
	logic [31:0] cover_count;
	logic [2:0]  bit_pos;
	logic [7:0]  gather_byte;
	logic [1:0]  xphase;
	logic [1:0]  hdr_idx;
	logic [31:0] stored_crc;
	logic [31:0] bytes_left;
	logic [31:0] payload_crc;

	lsbse_pkg::out_t expected_out_q [$];
	int              errors;
	int              items_sent;
	int              burst_left;
	bit              typed_active;
	lsbse_pkg::out_t typed_res;
	bit              long_hold_req;
	bit              long_hold_done;

	lsb_stego_frame_extractor_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
		int i;
		c = c ^ {24'd0, b};
		for (i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ lsbse_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] cover_for(logic v);
		logic [7:0] x;
		x = 8'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			x = {8{v}};
		end
		x[0] = v;
		return x;
	endfunction

	task automatic frame_clear();
		bit_pos = '0;
		gather_byte = '0;
		xphase = lsbse_pkg::PH_CRC;
		hdr_idx = '0;
		stored_crc = '0;
		bytes_left = '0;
		payload_crc = lsbse_pkg::CRC_INIT;
	endtask

	task automatic extract_step(input lsbse_pkg::in_t it, output bit got,
			output lsbse_pkg::out_t res);
		logic [7:0] done_byte;
		got = 1'b0;
		res = '0;
		if (it.frame_start) begin
			frame_clear();
		end
		if (xphase == lsbse_pkg::PH_DONE) begin
			return;
		end
		gather_byte[bit_pos] = it.cover_byte[0];
		if (bit_pos != 3'd7) begin
			bit_pos = bit_pos + 3'd1;
			return;
		end
		done_byte = gather_byte;
		bit_pos = '0;
		gather_byte = '0;
		if (xphase == lsbse_pkg::PH_CRC || xphase == lsbse_pkg::PH_LEN) begin
			if (xphase == lsbse_pkg::PH_CRC) begin
				stored_crc[hdr_idx*8 +: 8] = done_byte;
			end else begin
				bytes_left[hdr_idx*8 +: 8] = done_byte;
			end
			if (hdr_idx != 2'd3) begin
				hdr_idx = hdr_idx + 2'd1;
				return;
			end
			hdr_idx = '0;
			if (xphase == lsbse_pkg::PH_CRC) begin
				xphase = lsbse_pkg::PH_LEN;
				return;
			end
			if ({4'd0, cover_count[31:3]} < {1'b0, bytes_left} + 33'd8) begin
				xphase = lsbse_pkg::PH_DONE;
				got = 1'b1;
				res.last_result = 1'b1;
				res.status = lsbse_pkg::ST_CAPACITY;
			end else if (bytes_left == '0) begin
				xphase = lsbse_pkg::PH_DONE;
				got = 1'b1;
				res.last_result = 1'b1;
				res.status = (stored_crc == '0) ? lsbse_pkg::ST_MATCH : lsbse_pkg::ST_MISMATCH;
			end else begin
				xphase = lsbse_pkg::PH_PAY;
			end
			return;
		end
		payload_crc = crc32_update(payload_crc, done_byte);
		bytes_left = bytes_left - 32'd1;
		got = 1'b1;
		res.has_byte = 1'b1;
		res.payload_byte = done_byte;
		res.status = lsbse_pkg::ST_PROGRESS;
		if (bytes_left == '0) begin
			xphase = lsbse_pkg::PH_DONE;
			res.last_result = 1'b1;
			res.status = (~payload_crc == stored_crc) ?
				lsbse_pkg::ST_MATCH : lsbse_pkg::ST_MISMATCH;
		end
	endtask

	task automatic send_item(input lsbse_pkg::in_t it);
		bit              got;
		lsbse_pkg::out_t res;
		int              gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if ($urandom_range(0, 30) == 0) begin
				gap = 25;
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		items_sent++;
		extract_step(it, got, res);
		if (got) begin
			if (typed_active) begin
				res = typed_res;
			end
			expected_out_q.push_back(res);
		end
	endtask

	task automatic write_cfg(input logic [31:0] v);
		in_valid <= 1'b0;
		while (expected_out_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cover_count = v;
		cfg_we <= 1'b0;
	endtask

	task automatic run_frame(input logic [31:0] crc_field, input logic [31:0] len,
			input bit fix_crc, input int fill, input bit start, input int nbits,
			input int tail);
		logic [7:0] msg [$];
		logic [7:0] pay [$];
		logic [7:0] b;
		logic [31:0] c;
		int npay;
		int total;
		int i;
		lsbse_pkg::in_t it;
		npay = (len > 32'd64) ? 64 : int'(len);
		c = lsbse_pkg::CRC_INIT;
		for (i = 0; i < npay; i++) begin
			b = (fill < 0) ? 8'($urandom) : 8'(fill);
			pay.push_back(b);
			c = crc32_update(c, b);
		end
		if (fix_crc) begin
			crc_field = ~c;
		end
		for (i = 0; i < 4; i++) begin
			msg.push_back(crc_field[8*i +: 8]);
		end
		for (i = 0; i < 4; i++) begin
			msg.push_back(len[8*i +: 8]);
		end
		for (i = 0; i < npay; i++) begin
			msg.push_back(pay[i]);
		end
		total = msg.size() * 8;
		if (nbits > 0 && nbits < total) begin
			total = nbits;
		end
		for (i = 0; i < total; i++) begin
			b = msg[i / 8];
			it.frame_start = start && (i == 0);
			it.cover_byte = cover_for(b[i % 8]);
			send_item(it);
		end
		for (i = 0; i < tail; i++) begin
			it.frame_start = 1'b0;
			it.cover_byte = 8'($urandom);
			send_item(it);
		end
	endtask

	// receiver: checks accepted items and drives out_stall
	initial begin
		int              hold_cnt;
		int              mode_left;
		int              stall_pct;
		lsbse_pkg::out_t exp_res;
		hold_cnt = 0;
		mode_left = 0;
		stall_pct = 0;
		long_hold_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (expected_out_q.size() == 0) begin
					$display("%0t: unexpected item: actual %03h", $realtime, out_data);
					errors++;
				end else begin
					exp_res = expected_out_q.pop_front();
					if (out_data !== exp_res) begin
						$display("%0t: mismatch: expected %03h, actual %03h",
							$realtime, exp_res, out_data);
						errors++;
					end
				end
			end
			if (long_hold_req && !long_hold_done && hold_cnt == 0) begin
				hold_cnt = 300;
			end
			if (hold_cnt > 0) begin
				out_stall <= 1'b1;
				hold_cnt--;
				if (hold_cnt == 0) begin
					long_hold_done = 1'b1;
				end
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 20;
						3: stall_pct = 50;
						default: stall_pct = 85;
					endcase
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				out_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	initial begin
		int k;
		int kind;
		int nfr;
		int rand_start;
		int fill;
		logic [31:0] v;
		logic [31:0] ln;
		lsbse_pkg::in_t it;
		errors = 0;
		items_sent = 0;
		burst_left = 0;
		typed_active = 1'b0;
		typed_res = '0;
		long_hold_req = 1'b0;
		cover_count = '0;
		frame_clear();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < NROWS; k++) begin
			if (dir_rows[k].cfg !== cover_count) begin
				write_cfg(dir_rows[k].cfg);
			end
			typed_active = dir_rows[k].typed;
			typed_res = '{1'b0, 8'h00, 1'b1, dir_rows[k].st};
			run_frame(dir_rows[k].crc, dir_rows[k].len, dir_rows[k].fix_crc, dir_rows[k].fill,
				dir_rows[k].start, dir_rows[k].nbits, dir_rows[k].tail);
		end
		typed_active = 1'b0;

		// long receiver hold while a payload streams in
		write_cfg(CFG_MAX);
		long_hold_req = 1'b1;
		run_frame(32'h0, 32'd8, 1'b1, -1, 1'b1, 0, 0);

		nfr = 0;
		rand_start = items_sent;
		while (items_sent - rand_start < 250) begin
			if (nfr % 3 == 2) begin
				k = $urandom_range(0, 9);
				if (k == 0) begin
					v = '0;
				end else if (k <= 2) begin
					v = CFG_MAX;
				end else if (k <= 5) begin
					v = $urandom_range(8, 20) * 8 + $urandom_range(0, 7);
				end else begin
					v = $urandom;
				end
				write_cfg(v);
			end
			kind = $urandom_range(0, 19);
			if (kind < 14) begin
				ln = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
				fill = -1;
				if ($urandom_range(0, 9) == 0) begin
					fill = $urandom_range(0, 1) ? 255 : 0;
				end
				run_frame($urandom, ln, $urandom_range(0, 3) != 0, fill,
					$urandom_range(0, 9) != 0, 0, $urandom_range(0, 4));
			end else if (kind < 17) begin
				ln = $urandom_range(1, 10);
				run_frame($urandom, ln, $urandom_range(0, 1) != 0, -1, 1'b1,
					$urandom_range(1, 63 + 8 * int'(ln)), 0);
			end else if (kind < 19) begin
				run_frame($urandom, $urandom, 1'b0, -1, 1'b1, $urandom_range(64, 120), 0);
			end else begin
				k = $urandom_range(10, 40);
				repeat (k) begin
					it.frame_start = ($urandom_range(0, 30) == 0);
					it.cover_byte = 8'($urandom);
					send_item(it);
				end
			end
			nfr++;
		end

		in_valid <= 1'b0;
		while (expected_out_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_out_q.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+sv
sv/lsbse_pkg.sv
sv/lsbse_crc_byte.sv
sv/lsb_stego_frame_extractor_top.sv
test/lsb_stego_frame_extractor_top_tb.sv
